// ----- rtl/bbc_pkg.sv -----
package bbc_pkg;

  // Wide enough for a slot index or a rank at the largest supported slot count.
  localparam int IDX_W = 8;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_UNDER   = 2'd2;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e_t;

  typedef enum logic [2:0] {
    UPD_HIT,
    UPD_FILL,
    UPD_PIN,
    UPD_DEC,
    UPD_DEC_MRU
  } upd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    op_e_t       opcode;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [4:0] result_slot;
    logic       hit;
    logic       needs_disk_read;
    logic [1:0] status;
  } out_item_t;

  // Best candidates seen so far as the scan walks down the row of cells.
  typedef struct packed {
    logic             hit_found;
    logic             hit_valid;
    logic [IDX_W-1:0] hit_rank;
    logic [IDX_W-1:0] hit_slot;
    logic             free_found;
    logic [IDX_W-1:0] free_rank;
    logic [IDX_W-1:0] free_slot;
    logic             tgt_found;
    logic [7:0]       tgt_count;
    logic [IDX_W-1:0] tgt_rank;
  } token_t;

  typedef struct packed {
    logic             en;
    upd_kind_t        kind;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] old_rank;
  } upd_t;

endpackage

// ----- rtl/block_buffer_cache_lru_core.sv -----
// Buffer cache slot manager with LRU recency and per-slot reference counts.
// Input channel in_valid/in_ready/in_data carries one request item: read a
// device block, or release, pin or unpin a slot. Output channel
// out_valid/out_ready/out_data returns one result item per request.
// Each slot lives in one cell of a row; a request is answered by a scan
// token that walks the row one cell per cycle, collecting the most recent
// matching slot, the least recent free slot and the addressed slot.
// The result is registered in the update state, after the scan state has let
// the token walk the full row; one item is in flight at a time, so a new
// request is taken only once the previous one has left the update state.
// The state update and the result are both taken in the update cycle; if
// the previous result is still waiting, the block holds there until the
// receiver takes it. A new request is accepted while a result waits.
// Synchronous reset clears all slots to device 0, block 0, invalid, count
// zero, and gives each slot its own index as rank (highest most recent).
// Reset clears every slot at once; no clearing pass is needed.
module block_buffer_cache_lru_core #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbc_pkg::out_item_t  out_data
);
  import bbc_pkg::*;

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SLOT_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  in_item_t          req_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  upd_t              upd;
  token_t            tok [SLOT_COUNT+1];
  token_t            t;

  assign tok[0] = '0;
  assign t = tok[SLOT_COUNT];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    bbc_cell #(.SLOT_COUNT(SLOT_COUNT), .INDEX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .tok_in  (tok[i]),
      .upd     (upd),
      .tok_out (tok[i+1])
    );
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    upd = '0;
    upd.kind = UPD_HIT;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == SCAN_LAST) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = '0;
          out_nxt.status = STATUS_OK;
          if (req_r.opcode == OP_READ) begin
            if (t.hit_found) begin
              out_nxt.result_slot = t.hit_slot[4:0];
              out_nxt.hit = 1'b1;
              out_nxt.needs_disk_read = !t.hit_valid;
              upd.en = 1'b1;
              upd.kind = UPD_HIT;
              upd.slot = t.hit_slot;
            end else if (t.free_found) begin
              out_nxt.result_slot = t.free_slot[4:0];
              out_nxt.needs_disk_read = 1'b1;
              upd.en = 1'b1;
              upd.kind = UPD_FILL;
              upd.slot = t.free_slot;
            end else begin
              out_nxt.status = STATUS_NO_FREE;
            end
          end else begin
            out_nxt.result_slot = req_r.slot;
            upd.slot = IDX_W'(req_r.slot);
            upd.old_rank = t.tgt_rank;
            // A slot beyond the table is ignored with an ok status.
            if (t.tgt_found) begin
              if (req_r.opcode == OP_PIN) begin
                upd.en = 1'b1;
                upd.kind = UPD_PIN;
              end else if (t.tgt_count == 8'd0) begin
                out_nxt.status = STATUS_UNDER;
              end else begin
                upd.en = 1'b1;
                upd.kind = (req_r.opcode == OP_RELEASE && t.tgt_count == 8'd1) ?
                           UPD_DEC_MRU : UPD_DEC;
              end
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    out_r <= out_nxt;
  end

  a_no_free_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_NO_FREE |->
      out_data.result_slot == 5'd0 && !out_data.hit && !out_data.needs_disk_read)
    else $error("no-free result carries slot or flags");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.status == STATUS_OK)
    else $error("hit reported with error status");

  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared before the scan finished");

  a_update_only_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
    upd.en |=> state_r == ST_IDLE && out_valid_r)
    else $error("slot update without a result");

endmodule

// ----- rtl/bbc_cell.sv -----
module bbc_cell #(
  parameter int SLOT_COUNT = 32,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bbc_pkg::in_item_t req,
  input  bbc_pkg::token_t  tok_in,
  input  bbc_pkg::upd_t    upd,
  output bbc_pkg::token_t  tok_out
);
  import bbc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(SLOT_COUNT - 1);

  logic [7:0]       device_r, device_nxt;
  logic [31:0]      block_r, block_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [IDX_W-1:0] rank_r, rank_nxt;
  token_t           tok_r, tok_nxt;

  logic match;
  logic sel;

  assign match = (device_r == req.device) && (block_r == req.block_number);
  assign sel = upd.en && (upd.slot == MY_IDX);

  always_comb begin
    tok_nxt = tok_in;
    if (match && (!tok_in.hit_found || rank_r > tok_in.hit_rank)) begin
      tok_nxt.hit_found = 1'b1;
      tok_nxt.hit_valid = valid_r;
      tok_nxt.hit_rank = rank_r;
      tok_nxt.hit_slot = MY_IDX;
    end
    if (count_r == 8'd0 && (!tok_in.free_found || rank_r < tok_in.free_rank)) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_rank = rank_r;
      tok_nxt.free_slot = MY_IDX;
    end
    if (IDX_W'(req.slot) == MY_IDX) begin
      tok_nxt.tgt_found = 1'b1;
      tok_nxt.tgt_count = count_r;
      tok_nxt.tgt_rank = rank_r;
    end
  end

  always_comb begin
    device_nxt = device_r;
    block_nxt = block_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    rank_nxt = rank_r;
    if (upd.en) begin
      unique case (upd.kind)
        UPD_HIT: begin
          if (sel) begin
            valid_nxt = 1'b1;
            if (count_r != 8'hFF) count_nxt = count_r + 8'd1;
          end
        end
        UPD_FILL: begin
          if (sel) begin
            device_nxt = req.device;
            block_nxt = req.block_number;
            valid_nxt = 1'b1;
            count_nxt = 8'd1;
          end
        end
        UPD_PIN: begin
          if (sel && count_r != 8'hFF) count_nxt = count_r + 8'd1;
        end
        UPD_DEC: begin
          if (sel) count_nxt = count_r - 8'd1;
        end
        UPD_DEC_MRU: begin
          // The released slot becomes most recent; everything above it moves down.
          if (sel) begin
            count_nxt = count_r - 8'd1;
            rank_nxt = TOP_RANK;
          end else if (rank_r > upd.old_rank) begin
            rank_nxt = rank_r - IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_r <= '0;
      block_r <= '0;
      valid_r <= 1'b0;
      count_r <= '0;
      rank_r <= MY_IDX;
      tok_r <= '0;
    end else begin
      device_r <= device_nxt;
      block_r <= block_nxt;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      rank_r <= rank_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
